@@ hw/rtl/fdmc_pkg.sv @@
// shared types, constants and helpers for the footswitch debouncer
// no dependencies; imported by every module of the block
package fdmc_pkg;

   // switch count limits
   localparam int MAX_SWITCHES      = 6;
   localparam int SWITCH_COUNT_DEF  = 6;

   // field widths
   localparam int LEVELS_W   = 6;
   localparam int COUNT_W    = 16;
   localparam int SETTING_W  = 19;
   localparam int INDEX_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SWITCH_BASE = 3'd1;

   // reset values
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

   // setting word layout
   localparam int SET_ENABLE_BIT = 18;
   localparam logic [3:0] CC_STATUS_HI   = 4'hB;
   localparam logic [6:0] DEFAULT_VALUE  = 7'd127;
   localparam int DEFAULT_CTRL_BASE      = 20;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef logic [SETTING_W-1:0] setting_type;

   typedef struct packed {
      logic [INDEX_W-1:0] switch_index;
      logic [7:0]         status_byte;
      logic [6:0]         controller_number;
      logic [6:0]         controller_value;
      logic               last_message;
   } msg_type;

   // power-on setting: enabled, channel 1, controller 20 + i, value 127
   function automatic setting_type default_setting(input int idx);
      logic [6:0] ctrl;
      ctrl = 7'(DEFAULT_CTRL_BASE + idx);
      return {1'b1, 4'd0, ctrl, DEFAULT_VALUE};
   endfunction

endpackage

@@ hw/rtl/fdmc_front.sv @@
// front part: per-switch debounce state, updated once per accepted request
// depends on fdmc_pkg; produces a mask of new enabled presses for the queue
module fdmc_front
   import fdmc_pkg::*;
#(
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [LEVELS_W-1:0]           raw_levels,
   input  logic [COUNT_W-1:0]            debounce_ticks,
   input  setting_type [SWITCH_COUNT-1:0] setting,
   output logic                          push_valid,
   output logic [SWITCH_COUNT-1:0]       push_mask
);

   logic [SWITCH_COUNT-1:0] stable_ff, stable_in;
   logic [SWITCH_COUNT-1:0] prev_ff, prev_in;
   logic [COUNT_W-1:0]      count_ff [SWITCH_COUNT];
   logic [COUNT_W-1:0]      count_in [SWITCH_COUNT];
   logic [SWITCH_COUNT-1:0] press;

   // per-switch debounce, all switches side by side
   always_comb begin
      logic smp;
      logic take;
      for (int i = 0; i < SWITCH_COUNT; i++) begin
         smp = raw_levels[i];
         if (smp != prev_ff[i]) begin
            count_in[i] = '0;
         end else if (count_ff[i] != COUNT_MAX) begin
            count_in[i] = count_ff[i] + 1'b1;
         end else begin
            count_in[i] = count_ff[i];
         end
         take = (count_in[i] > debounce_ticks) && (smp != stable_ff[i]);
         stable_in[i] = take ? smp : stable_ff[i];
         prev_in[i]   = smp;
         press[i]     = take && !smp && setting[i][SET_ENABLE_BIT];
      end
   end

   assign push_valid = accept && (press != '0);
   assign push_mask  = press;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '0;
         prev_ff   <= '0;
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            count_ff[i] <= COUNT_MAX;
         end
      end else if (accept) begin
         stable_ff <= stable_in;
         prev_ff   <= prev_in;
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

endmodule

@@ hw/rtl/fdmc_queue.sv @@
// short queue of press masks between front and back
// depends on fdmc_pkg for depth and pointer widths
module fdmc_queue
   import fdmc_pkg::*;
#(
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  logic [SWITCH_COUNT-1:0] push_mask,
   output logic                    full,
   output logic                    pop_valid,
   output logic [SWITCH_COUNT-1:0] pop_mask,
   input  logic                    pop_ready
);

   logic [SWITCH_COUNT-1:0] mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_mask  = mem[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_mask;
      end
   end

endmodule

@@ hw/rtl/fdmc_back.sv @@
// back part: turns each press mask into control change messages, lowest switch first
// depends on fdmc_pkg; drives the registered result slot
module fdmc_back
   import fdmc_pkg::*;
#(
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   input  logic [SWITCH_COUNT-1:0]        pop_mask,
   output logic                           pop_ready,
   input  setting_type [SWITCH_COUNT-1:0] setting,
   output logic                           out_valid,
   output msg_type                        out_msg,
   input  logic                           out_ready
);

   logic [SWITCH_COUNT-1:0] pend_ff, pend_in;
   logic                    valid_ff, valid_in;
   msg_type                 msg_ff, msg_in;
   logic [SWITCH_COUNT-1:0] cur, lowest, rest;
   logic                    slot_free, emit;
   setting_type             sel;
   logic [INDEX_W-1:0]      idx;

   // pick the lowest pending switch and build its message
   always_comb begin
      cur       = (pend_ff != '0) ? pend_ff : (pop_valid ? pop_mask : '0);
      slot_free = !valid_ff || out_ready;
      lowest    = cur & (~cur + 1'b1);
      rest      = cur & ~lowest;
      emit      = slot_free && (cur != '0);
      pop_ready = slot_free && (pend_ff == '0);

      sel = '0;
      idx = '0;
      for (int i = 0; i < SWITCH_COUNT; i++) begin
         if (lowest[i]) begin
            sel = setting[i];
            idx = INDEX_W'(i);
         end
      end

      msg_in.switch_index      = idx;
      msg_in.status_byte       = {CC_STATUS_HI, sel[17:14]};
      msg_in.controller_number = sel[13:7];
      msg_in.controller_value  = sel[6:0];
      msg_in.last_message      = (rest == '0);

      pend_in  = emit ? rest : pend_ff;
      valid_in = emit ? 1'b1 : (slot_free ? 1'b0 : valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         msg_ff <= msg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_msg   = msg_ff;

endmodule

@@ hw/rtl/footswitch_debounce_midi_cc.sv @@
// top level: footswitch debouncer with midi control change output
// depends on fdmc_pkg, fdmc_front, fdmc_queue and fdmc_back; holds the settings registers
//
//   channel   direction  ports                          payload
//   req       in         req_tvalid/tready/tdata        raw_levels
//   rsp       out        rsp_tvalid/tready/tdata/tlast  index, status, controller, value
//   csr       in         csr_wr_en/index/wdata          debounce_ticks, switch settings
//
// one request is taken per cycle while the press queue (4 entries) has room
// each request with n new presses gives n responses, one per cycle from the back part while rsp_tready is high
// when requests carry presses, the sustained rate is set by the back part and its single result register
// reset is synchronous; it resets debounce state, clears queue and result slot, loads settings
// a stalled rsp side fills the queue, after which req_tready drops
module footswitch_debounce_midi_cc
   import fdmc_pkg::*;
#(
   parameter int SWITCH_COUNT = SWITCH_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // [5:0] raw_levels
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // [2:0] switch_index, [10:3] status_byte,
                                              // [17:11] controller_number,
                                              // [24:18] controller_value
   output logic                   rsp_tlast,
   // configuration writes
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SETTING_W-1:0]   csr_wdata
);

   logic [COUNT_W-1:0]            debounce_ff;
   setting_type [SWITCH_COUNT-1:0] setting_ff;
   logic                          accept;
   logic                          push_valid, full;
   logic [SWITCH_COUNT-1:0]       push_mask, pop_mask;
   logic                          pop_valid, pop_ready;
   msg_type                       msg;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            setting_ff[i] <= default_setting(i);
         end
      end else if (csr_wr_en) begin
         if (csr_index == REG_DEBOUNCE) begin
            debounce_ff <= csr_wdata[COUNT_W-1:0];
         end
         for (int i = 0; i < SWITCH_COUNT; i++) begin
            if (csr_index == CSR_INDEX_W'(REG_SWITCH_BASE + i)) begin
               setting_ff[i] <= csr_wdata;
            end
         end
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   fdmc_front #(.SWITCH_COUNT(SWITCH_COUNT)) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .raw_levels     (req_tdata[LEVELS_W-1:0]),
      .debounce_ticks (debounce_ff),
      .setting        (setting_ff),
      .push_valid     (push_valid),
      .push_mask      (push_mask)
   );

   fdmc_queue #(.SWITCH_COUNT(SWITCH_COUNT)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_mask  (push_mask),
      .full       (full),
      .pop_valid  (pop_valid),
      .pop_mask   (pop_mask),
      .pop_ready  (pop_ready)
   );

   fdmc_back #(.SWITCH_COUNT(SWITCH_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_mask  (pop_mask),
      .pop_ready (pop_ready),
      .setting   (setting_ff),
      .out_valid (rsp_tvalid),
      .out_msg   (msg),
      .out_ready (rsp_tready)
   );

   // response packing
   assign rsp_tdata = {7'd0, msg.controller_value, msg.controller_number,
                       msg.status_byte, msg.switch_index};
   assign rsp_tlast = msg.last_message;

   // checks
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[2:0]) < SWITCH_COUNT))
      else $error("response for a switch that does not exist");

   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:7] == CC_STATUS_HI))
      else $error("response status is not a control change");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("message run ended without a last mark");

endmodule
